/* rtl/rsra_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated scan readout package
// Widths, limits and register indexes shared by the readout address block.
// ----------------------------------------------------------------------------
package rsra_pkg;

	// Field widths of the configuration registers and the result.
	localparam int COL_W   = 14;
	localparam int LINE_W  = 16;
	localparam int LPI_W   = 12;
	localparam int ROW_W   = 13;
	localparam int IDX_W   = 31;
	localparam int PIX_W   = 29;
	localparam int STEP_W  = 18;
	localparam int CFG_W   = 16;
	localparam int CFG_A_W = 3;

	// Largest raw line length that the buffer holds.
	localparam int MAX_COLUMNS = 8192;

	// Columns of each raw line that never reach the output image.
	localparam int EDGE_COLUMNS = 40;

	// Resolutions that select a channel shift.
	localparam logic [LPI_W-1:0] LPI_500  = 12'd500;
	localparam logic [LPI_W-1:0] LPI_1000 = 12'd1000;
	localparam logic [LPI_W-1:0] LPI_2000 = 12'd2000;
	localparam logic [LPI_W-1:0] LPI_4000 = 12'd4000;

	// Reset value of the line column count register; the other registers reset to zero.
	localparam logic [COL_W-1:0] LINE_COLUMNS_RESET = 14'd4040;

	// Configuration register indexes.
	typedef enum logic [CFG_A_W-1:0] {
		CFG_LINE_COLUMNS       = 3'd0,
		CFG_LINE_COUNT         = 3'd1,
		CFG_LINES_PER_INCH     = 3'd2,
		CFG_SHIFT_ALREADY_DONE = 3'd3,
		CFG_LEFT_TO_RIGHT      = 3'd4
	} cfg_index_t;

endpackage
`default_nettype wire

/* rtl/rotated_scan_readout_addresses.sv */
`default_nettype none
// Pipeline: a request's result passes the stage 1 register (counter stage), the stage 2
// register (pixel-offset multiply stage) and the output register (index stage).
// Throughput: one request per clock while in_stall is low; each pipeline stage loads
// whenever the stage after it is free or moves on, so an output stall reaches back to in_stall.
// Reset: arst_n clears the counters, the finished flag, the stage valid bits and
// returns the configuration registers to their reset values; no clearing pass.
// ----------------------------------------------------------------------------
// Rotated scan readout address generator
// Walks the output raster row by row and gives the red, green and blue sample
// indices that read the raw buffer rotated by 90 degrees with the channel
// line offset removed.
// ----------------------------------------------------------------------------
module rotated_scan_readout_addresses
	import rsra_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port.
	input  wire logic                 cfg_we,
	input  wire logic [CFG_A_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// Request channel.
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 restart,
	// Result channel.
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [IDX_W-1:0]          red_index,
	output logic [IDX_W-1:0]          green_index,
	output logic [IDX_W-1:0]          blue_index,
	output logic [ROW_W-1:0]          output_row,
	output logic [LINE_W-1:0]         output_column,
	output logic                      row_end,
	output logic                      image_end
);

	// Configuration registers.
	logic [COL_W-1:0]  line_columns_q;
	logic [LINE_W-1:0] line_count_q;
	logic [LPI_W-1:0]  lines_per_inch_q;
	logic              shift_already_done_q;
	logic              left_to_right_q;

	// Raster position state.
	logic [ROW_W-1:0]  row_q;
	logic [LINE_W-1:0] col_q;
	logic              finished_q;

	// Derived geometry.
	logic [3:0]        shift;
	logic [COL_W-1:0]  cols;
	logic [ROW_W-1:0]  out_rows;
	logic [LINE_W-1:0] rows_in;
	logic [STEP_W-1:0] step;

	// Counter stage signals.
	logic              accept;
	logic [ROW_W-1:0]  r0;
	logic [LINE_W-1:0] c0;
	logic              f0;
	logic              hit;
	logic              last_col;
	logic              last_row;
	logic [ROW_W-1:0]  row_d;
	logic [LINE_W-1:0] col_d;
	logic              finished_d;
	logic [LINE_W-1:0] in_row_d;
	logic [COL_W-1:0]  in_col_wide;

	// Pipeline handshake.
	logic              ready_out;
	logic              ready_s2;

	// Stage 1: raster position of the pixel.
	logic              valid_s1;
	logic [LINE_W-1:0] in_row_s1;
	logic [ROW_W-1:0]  in_col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [LINE_W-1:0] col_s1;
	logic              row_end_s1;
	logic              image_end_s1;

	// Stage 2: pixel offset in the buffer.
	logic              valid_s2;
	logic [PIX_W-1:0]  pix_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [LINE_W-1:0] col_s2;
	logic              row_end_s2;
	logic              image_end_s2;

	// Output register.
	logic              out_valid_q;
	logic [IDX_W-1:0]  red_q;
	logic [IDX_W-1:0]  green_q;
	logic [IDX_W-1:0]  blue_q;
	logic [ROW_W-1:0]  row_q_out;
	logic [LINE_W-1:0] col_q_out;
	logic              row_end_q;
	logic              image_end_q;

	// Index stage arithmetic.
	logic [IDX_W-1:0]  base;
	logic [IDX_W-1:0]  step1;
	logic [IDX_W-1:0]  step2;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_columns_q       <= LINE_COLUMNS_RESET;
			line_count_q         <= '0;
			lines_per_inch_q     <= '0;
			shift_already_done_q <= 1'b0;
			left_to_right_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_COLUMNS:       line_columns_q       <= cfg_data[COL_W-1:0];
				CFG_LINE_COUNT:         line_count_q         <= cfg_data[LINE_W-1:0];
				CFG_LINES_PER_INCH:     lines_per_inch_q     <= cfg_data[LPI_W-1:0];
				CFG_SHIFT_ALREADY_DONE: shift_already_done_q <= cfg_data[0];
				CFG_LEFT_TO_RIGHT:      left_to_right_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Channel shift in lines, taken from the resolution.
	always_comb begin
		priority if (shift_already_done_q) shift = 4'd0;
		else if (lines_per_inch_q == LPI_500)  shift = 4'd1;
		else if (lines_per_inch_q == LPI_1000) shift = 4'd2;
		else if (lines_per_inch_q == LPI_2000) shift = 4'd4;
		else if (lines_per_inch_q == LPI_4000) shift = 4'd8;
		else shift = 4'd0;
	end

	// Image geometry. The column count is clamped to MAX_COLUMNS; the line count is not limited.
	always_comb begin
		cols = (line_columns_q > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
			: line_columns_q;
		if (cols > COL_W'(EDGE_COLUMNS)) begin
			out_rows = ROW_W'(cols - COL_W'(EDGE_COLUMNS));
		end else begin
			out_rows = '0;
		end
		if (line_count_q > LINE_W'({shift, 1'b0})) begin
			rows_in = line_count_q - LINE_W'({shift, 1'b0});
		end else begin
			rows_in = '0;
		end
		// Distance in samples between two colour planes: 3 * shift * columns.
		step = STEP_W'(STEP_W'(shift) * STEP_W'(cols) * STEP_W'(3));
	end

	// Handshake: a stage loads when it is empty or its contents move on.
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !valid_s2 || ready_out;
	assign in_stall  = valid_s1 && !ready_s2;
	assign accept    = in_valid && !in_stall;

	// Counter stage: apply restart, test the position, find the next one.
	always_comb begin
		r0 = restart ? '0 : row_q;
		c0 = restart ? '0 : col_q;
		f0 = restart ? 1'b0 : finished_q;
		hit = !f0 && (out_rows != '0) && (rows_in != '0)
			&& (r0 < out_rows) && (c0 < rows_in);
		last_col = (c0 == rows_in - LINE_W'(1));
		last_row = (r0 == out_rows - ROW_W'(1));

		row_d      = r0;
		col_d      = c0;
		finished_d = f0;
		if (!f0 && !hit) begin
			// Empty raster or a position outside the image.
			finished_d = 1'b1;
		end else if (hit) begin
			if (!last_col) begin
				col_d = c0 + LINE_W'(1);
			end else begin
				col_d = '0;
				if (last_row) begin
					finished_d = 1'b1;
				end else begin
					row_d = r0 + ROW_W'(1);
				end
			end
		end

		// Raw line and raw column that this output pixel reads.
		if (left_to_right_q) begin
			in_row_d = LINE_W'({shift, 1'b0}) + c0;
		end else begin
			in_row_d = rows_in - LINE_W'(1) - c0;
		end
		in_col_wide = cols - COL_W'(1) - COL_W'(r0);
	end

	// Position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			finished_q <= 1'b0;
		end else if (accept) begin
			row_q      <= row_d;
			col_q      <= col_d;
			finished_q <= finished_d;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || ready_s2) begin
			valid_s1 <= accept && hit;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_row_s1    <= in_row_d;
			in_col_s1    <= in_col_wide[ROW_W-1:0];
			row_s1       <= r0;
			col_s1       <= c0;
			row_end_s1   <= last_col;
			image_end_s1 <= last_col && last_row;
		end
	end

	// Stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: pixel offset = raw line * columns + raw column.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			pix_s2       <= PIX_W'(PIX_W'(in_row_s1) * PIX_W'(cols)) + PIX_W'(in_col_s1);
			row_s2       <= row_s1;
			col_s2       <= col_s1;
			row_end_s2   <= row_end_s1;
			image_end_s2 <= image_end_s1;
		end
	end

	// Index stage: three samples per pixel, colour planes one step apart.
	always_comb begin
		base  = IDX_W'({pix_s2, 1'b0}) + IDX_W'(pix_s2);
		step1 = IDX_W'(step);
		step2 = IDX_W'({step, 1'b0});
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			red_q <= base;
			if (left_to_right_q) begin
				green_q <= base + IDX_W'(1) - step1;
				blue_q  <= base + IDX_W'(2) - step2;
			end else begin
				green_q <= base + IDX_W'(1) + step1;
				blue_q  <= base + IDX_W'(2) + step2;
			end
			row_q_out   <= row_s2;
			col_q_out   <= col_s2;
			row_end_q   <= row_end_s2;
			image_end_q <= image_end_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign red_index     = red_q;
	assign green_index   = green_q;
	assign blue_index    = blue_q;
	assign output_row    = row_q_out;
	assign output_column = col_q_out;
	assign row_end       = row_end_q;
	assign image_end     = image_end_q;

endmodule
`default_nettype wire

/* rtl/rsra_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated scan readout checker
// Port-level properties of the readout address generator, bound to its top.
// ----------------------------------------------------------------------------
module rsra_checker
	import rsra_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [IDX_W-1:0]     red_index,
	input wire logic [IDX_W-1:0]     green_index,
	input wire logic [IDX_W-1:0]     blue_index,
	input wire logic [ROW_W-1:0]     output_row,
	input wire logic [LINE_W-1:0]    output_column,
	input wire logic                 row_end,
	input wire logic                 image_end
);

	// A stalled result stays in place with its three indices, row and column.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_index)
			&& $stable(green_index) && $stable(blue_index)
			&& $stable(output_row) && $stable(output_column))
		else $error("stalled result changed");

	// The last pixel of the image is always the last pixel of its row.
	a_image_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end outside row end");

	// The three colour planes are equally spaced.
	a_plane_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> IDX_W'(blue_index - green_index) == IDX_W'(green_index - red_index))
		else $error("colour plane spacing mismatch");

	// The red sample starts a pixel of three samples.
	a_red_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red_index % 3) == 0)
		else $error("red index not pixel aligned");

endmodule

bind rotated_scan_readout_addresses rsra_checker u_rsra_checker (.*);
`default_nettype wire

/* test/tb_rotated_scan_readout_addresses.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotated scan readout address generator testbench
// Sends pixel requests and register settings to the address generator and
// checks every result, field by field, against a behavioral model of the
// rotated raster walk. A short scripted part covers the corner cases; random
// settings and request bursts follow under changing handshake pressure.
// ----------------------------------------------------------------------------
module tb_rotated_scan_readout_addresses;
	import rsra_pkg::*;

	localparam int RANDOM_ITEMS  = 600;
	localparam int PHASE_ITEMS   = 210;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT  = 10;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam logic [CFG_A_W-1:0] FIRST_UNUSED_INDEX = CFG_A_W'(CFG_LEFT_TO_RIGHT + 1);

	// One output pixel: its three sample indices, position and end marks.
	typedef struct {
		logic [IDX_W-1:0]  red;
		logic [IDX_W-1:0]  green;
		logic [IDX_W-1:0]  blue;
		logic [ROW_W-1:0]  row;
		logic [LINE_W-1:0] column;
		logic              row_last;
		logic              image_last;
	} pixel_addr_t;

	typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

	// A scripted step: either a register write or a request, with an optional
	// hand-written expectation.
	typedef struct {
		row_kind_t        kind;
		cfg_index_t       index;
		logic [CFG_W-1:0] data;
		logic             rs;
		bit               typed;
		bit               produces;
		pixel_addr_t      px;
	} script_row_t;

	localparam pixel_addr_t NO_PIXEL = '{default: '0};
	// Single-pixel raster of 41 columns and one line without shift.
	localparam pixel_addr_t CORNER_PIXEL = '{red: 31'd120, green: 31'd121, blue: 31'd122,
		row: '0, column: '0, row_last: 1'b1, image_last: 1'b1};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_A_W-1:0]  cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic                restart;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [IDX_W-1:0]    red_index;
	logic [IDX_W-1:0]    green_index;
	logic [IDX_W-1:0]    blue_index;
	logic [ROW_W-1:0]    output_row;
	logic [LINE_W-1:0]   output_column;
	logic                row_end;
	logic                image_end;

	// Shadow copies of the registers and of the raster walk state.
	logic [COL_W-1:0]    shadow_cols = LINE_COLUMNS_RESET;
	logic [LINE_W-1:0]   shadow_lines = '0;
	logic [LPI_W-1:0]    shadow_lpi = '0;
	logic                shadow_shift_done = 1'b0;
	logic                shadow_ltr = 1'b0;
	logic [ROW_W-1:0]    walk_row = '0;
	logic [LINE_W-1:0]   walk_col = '0;
	logic                walk_done = 1'b0;

	pixel_addr_t         pending_pixels[$];
	script_row_t         script[$];
	int                  mismatch_count = 0;
	int                  checked_count = 0;
	int                  requests_sent = 0;
	int                  send_idle_pct = 25;
	int                  recv_idle_pct = 75;

	rotated_scan_readout_addresses uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.red_index     (red_index),
		.green_index   (green_index),
		.blue_index    (blue_index),
		.output_row    (output_row),
		.output_column (output_column),
		.row_end       (row_end),
		.image_end     (image_end)
	);

	// Channel line offset selected by the resolution.
	function automatic int unsigned channel_shift(input logic [LPI_W-1:0] lpi,
			input logic done);
		int unsigned s;
		case (lpi)
			LPI_500:  s = 1;
			LPI_1000: s = 2;
			LPI_2000: s = 4;
			LPI_4000: s = 8;
			default:  s = 0;
		endcase
		return done ? 0 : s;
	endfunction

	// Steps the raster walk by one request and returns whether a pixel comes out.
	function automatic bit predict_pixel(input logic rs, output pixel_addr_t px);
		logic [63:0] cols, shift, rows_in, out_rows, r, c, in_row, base, step, g, b;
		px = NO_PIXEL;
		shift = 64'(channel_shift(shadow_lpi, shadow_shift_done));
		cols = (shadow_cols > MAX_COLUMNS) ? 64'(MAX_COLUMNS) : 64'(shadow_cols);
		rows_in = (64'(shadow_lines) > 2 * shift) ? 64'(shadow_lines) - 2 * shift : 64'd0;
		out_rows = (cols > EDGE_COLUMNS) ? cols - EDGE_COLUMNS : 64'd0;
		if (rs) begin
			walk_row = '0;
			walk_col = '0;
			walk_done = 1'b0;
		end
		if (walk_done)
			return 1'b0;
		r = 64'(walk_row);
		c = 64'(walk_col);
		// Counters outside the raster, or an empty raster, end the walk silently.
		if (out_rows == 0 || rows_in == 0 || r >= out_rows || c >= rows_in) begin
			walk_done = 1'b1;
			return 1'b0;
		end
		in_row = shadow_ltr ? 2 * shift + c : rows_in - 1 - c;
		base = 3 * (in_row * cols + (cols - 1 - r));
		step = 3 * shift * cols;
		g = shadow_ltr ? base + 1 - step : base + 1 + step;
		b = shadow_ltr ? base + 2 - 2 * step : base + 2 + 2 * step;
		px.red = base[IDX_W-1:0];
		px.green = g[IDX_W-1:0];
		px.blue = b[IDX_W-1:0];
		px.row = r[ROW_W-1:0];
		px.column = c[LINE_W-1:0];
		px.row_last = (c == rows_in - 1);
		px.image_last = (c == rows_in - 1) && (r == out_rows - 1);
		// Advance along the output row, then down to the next row.
		if (c + 1 < rows_in) begin
			walk_col = LINE_W'(c + 1);
		end else begin
			walk_col = '0;
			if (r + 1 < out_rows)
				walk_row = ROW_W'(r + 1);
			else
				walk_done = 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Register write; with junk set, bits above the register width are random.
	task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] value,
			input bit junk);
		logic [CFG_W-1:0] keep_mask;
		logic [CFG_W-1:0] word;
		case (idx)
			CFG_LINE_COLUMNS:       keep_mask = CFG_W'((1 << COL_W) - 1);
			CFG_LINE_COUNT:         keep_mask = CFG_W'((1 << LINE_W) - 1);
			CFG_LINES_PER_INCH:     keep_mask = CFG_W'((1 << LPI_W) - 1);
			CFG_SHIFT_ALREADY_DONE: keep_mask = CFG_W'(1);
			CFG_LEFT_TO_RIGHT:      keep_mask = CFG_W'(1);
			default:                keep_mask = '0;
		endcase
		word = junk ? ((CFG_W'($urandom) & ~keep_mask) | (value & keep_mask)) : value;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_LINE_COLUMNS:       shadow_cols = word[COL_W-1:0];
			CFG_LINE_COUNT:         shadow_lines = word[LINE_W-1:0];
			CFG_LINES_PER_INCH:     shadow_lpi = word[LPI_W-1:0];
			CFG_SHIFT_ALREADY_DONE: shadow_shift_done = word[0];
			CFG_LEFT_TO_RIGHT:      shadow_ltr = word[0];
			default: ;
		endcase
	endtask

	// Sends one request, with a random gap before it, and predicts its result.
	task automatic push_request(input logic rs, output bit produces, output pixel_addr_t px);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
		produces = predict_pixel(rs, px);
		requests_sent++;
		// Swap the idle pattern of the two sides, then stop idling altogether.
		if (requests_sent >= 2 * PHASE_ITEMS) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end else if (requests_sent >= PHASE_ITEMS) begin
			send_idle_pct = 75;
			recv_idle_pct = 25;
		end
	endtask

	// Holds off requests until every pixel is back and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side back-pressure.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Compare each accepted pixel with the oldest prediction.
	always @(posedge clk) begin : result_check
		pixel_addr_t want;
		if (arst_n && out_valid && !out_stall) begin
			checked_count++;
			if (pending_pixels.size() == 0) begin
				note_mismatch($sformatf("unexpected pixel %0d/%0d/%0d at (%0d,%0d)",
					red_index, green_index, blue_index, output_row, output_column));
			end else begin
				want = pending_pixels.pop_front();
				if (red_index !== want.red || green_index !== want.green ||
						blue_index !== want.blue || output_row !== want.row ||
						output_column !== want.column || row_end !== want.row_last ||
						image_end !== want.image_last)
					note_mismatch($sformatf({"pixel %0d: expected %0d/%0d/%0d (%0d,%0d) ",
						"ends %b%b, got %0d/%0d/%0d (%0d,%0d) ends %b%b"}, checked_count,
						want.red, want.green, want.blue, want.row, want.column,
						want.row_last, want.image_last, red_index, green_index,
						blue_index, output_row, output_column, row_end, image_end));
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("tb_rotated_scan_readout_addresses: done, errors");
		$finish;
	end

	initial begin
		bit          produces;
		pixel_addr_t px;
		int          random_sent;
		int          burst;
		int          pick;
		int unsigned cols_val;
		int unsigned lines_val;
		int unsigned lpi_val;
		int unsigned shift_val;
		bit          done_val;
		bit          ltr_val;
		bit          carry_on;

		in_valid <= 1'b0;
		restart <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted corner cases: first request without restart, finished walk,
		// largest raster, direction and size changes mid-image, shift already
		// applied, empty raster and every shift value.
		script = '{
			'{ROW_CFG, CFG_LINE_COLUMNS,       16'd41,    1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd1,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b1, 1'b1, CORNER_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b1, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b1, 1'b1, CORNER_PIXEL},
			'{ROW_CFG, CFG_LINE_COLUMNS,       16'd16383, 1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd65535, 1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINES_PER_INCH,     16'd4000,  1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LEFT_TO_RIGHT,      16'd1,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINES_PER_INCH,     16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd2,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b1, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COLUMNS,       16'd41,    1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd1,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINES_PER_INCH,     16'd500,   1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_SHIFT_ALREADY_DONE, 16'd1,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LEFT_TO_RIGHT,      16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b1, 1'b1, CORNER_PIXEL},
			'{ROW_CFG, CFG_LINE_COLUMNS,       16'd40,    1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b1, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COLUMNS,       16'd42,    1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd3,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_SHIFT_ALREADY_DONE, 16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LEFT_TO_RIGHT,      16'd1,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINES_PER_INCH,     16'd1000,  1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd5,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINES_PER_INCH,     16'd2000,  1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_CFG, CFG_LINE_COUNT,         16'd9,     1'b0, 1'b0, 1'b0, NO_PIXEL},
			'{ROW_REQ, CFG_LINE_COLUMNS,       16'd0,     1'b1, 1'b0, 1'b0, NO_PIXEL}
		};

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				settle();
				write_reg(script[i].index, script[i].data, 1'b0);
			end else begin
				push_request(script[i].rs, produces, px);
				if (script[i].typed) begin
					produces = script[i].produces;
					px = script[i].px;
				end
				if (produces)
					pending_pixels.push_back(px);
			end
		end

		// Random settings, each followed by a burst that mostly walks the raster.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			settle();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				cols_val = $urandom_range(0, EDGE_COLUMNS);
			else if (pick == 1)
				cols_val = $urandom_range(MAX_COLUMNS - 64, (1 << COL_W) - 1);
			else
				cols_val = $urandom_range(EDGE_COLUMNS + 1, EDGE_COLUMNS + 6);
			case ($urandom_range(0, 5))
				0:       lpi_val = $urandom_range(0, (1 << LPI_W) - 1);
				1:       lpi_val = LPI_500;
				2:       lpi_val = LPI_1000;
				3:       lpi_val = LPI_2000;
				4:       lpi_val = LPI_4000;
				default: lpi_val = 0;
			endcase
			done_val = ($urandom_range(0, 3) == 0);
			ltr_val = $urandom_range(0, 1);
			shift_val = channel_shift(lpi_val[LPI_W-1:0], done_val);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				lines_val = $urandom_range(0, 2 * shift_val);
			else if (pick == 1)
				lines_val = $urandom_range(0, (1 << LINE_W) - 1);
			else
				lines_val = 2 * shift_val + $urandom_range(1, 8);

			write_reg(CFG_LINE_COLUMNS, CFG_W'(cols_val), 1'b1);
			write_reg(CFG_LINE_COUNT, CFG_W'(lines_val), 1'b1);
			write_reg(CFG_LINES_PER_INCH, CFG_W'(lpi_val), 1'b1);
			write_reg(CFG_SHIFT_ALREADY_DONE, CFG_W'(done_val), 1'b1);
			write_reg(CFG_LEFT_TO_RIGHT, CFG_W'(ltr_val), 1'b1);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_A_W'($urandom_range(FIRST_UNUSED_INDEX, (1 << CFG_A_W) - 1)),
					'0, 1'b1);

			// Small rasters are walked to the end and a little past it.
			if (cols_val > EDGE_COLUMNS && cols_val <= EDGE_COLUMNS + 6 &&
					lines_val > 2 * shift_val && lines_val <= 2 * shift_val + 8)
				burst = (cols_val - EDGE_COLUMNS) * (lines_val - 2 * shift_val) +
					$urandom_range(0, 3);
			else
				burst = $urandom_range(3, 20);
			// Now and then keep the old counters to land outside the new raster.
			carry_on = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < burst; k++) begin
				push_request((k == 0) ? !carry_on : ($urandom_range(0, 24) == 0),
					produces, px);
				if (produces)
					pending_pixels.push_back(px);
				random_sent++;
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("tb_rotated_scan_readout_addresses: done, clean");
		else
			$display("tb_rotated_scan_readout_addresses: done, errors");
		$finish;
	end

endmodule
